>>> rtl/iir_filter_transposed_df2_defines.svh
// ------------------------------------------------------------------------
// Assertion macros for the transposed direct form II IIR filter
// Shared property forms used by the port checker.
// ------------------------------------------------------------------------
`ifndef IIR_FILTER_TRANSPOSED_DF2_DEFINES_SVH
`define IIR_FILTER_TRANSPOSED_DF2_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRTDF2_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iirtdf2 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IIRTDF2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iirtdf2 check failed");

`endif

>>> rtl/iirtdf2_pkg.sv
// ------------------------------------------------------------------------
// iirtdf2_pkg
// Types, register indexes, reset values and fixed-point helpers for the
// transposed direct form II IIR filter.
// ------------------------------------------------------------------------
`default_nettype none

package iirtdf2_pkg;

    localparam int ORDER_DEF    = 3;
    localparam int CHANNELS_DEF = 2;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int X_W      = 28;
    localparam int PROD_W   = 64;
    localparam int RND_W    = 36;
    localparam int DELAY_W  = 48;
    localparam int ACC_W    = 50;
    localparam int CFG_N    = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_B0   = 3'd0;
    localparam t_cfg_idx CFG_B1   = 3'd1;
    localparam t_cfg_idx CFG_B2   = 3'd2;
    localparam t_cfg_idx CFG_B3   = 3'd3;
    localparam t_cfg_idx CFG_A1   = 3'd4;
    localparam t_cfg_idx CFG_A2   = 3'd5;
    localparam t_cfg_idx CFG_A3   = 3'd6;
    localparam t_cfg_idx CFG_GAIN = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh1000_0000;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sh0000_0000;

    localparam logic signed [PROD_W-1:0] HALF_Q28 = 64'sh0000_0000_0800_0000;

    localparam logic signed [ACC_W-1:0] SAT24_HI = 50'sh0_0000_007F_FFFF;
    localparam logic signed [ACC_W-1:0] SAT24_LO = -50'sh0_0000_0080_0000;
    localparam logic signed [ACC_W-1:0] SAT48_HI = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT48_LO = -50'sh0_8000_0000_0000;

    // Round half towards plus infinity, then drop the 28 fraction bits.
    function automatic logic signed [RND_W-1:0] round_q28(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        v = p + HALF_Q28;
        return v[PROD_W-1:28];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT24_HI) begin
            r = SAT24_HI[SAMPLE_W-1:0];
        end else if (v < SAT24_LO) begin
            r = SAT24_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [DELAY_W-1:0] r;
        if (v > SAT48_HI) begin
            r = SAT48_HI[DELAY_W-1:0];
        end else if (v < SAT48_LO) begin
            r = SAT48_LO[DELAY_W-1:0];
        end else begin
            r = v[DELAY_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/iir_filter_transposed_df2.sv
// Each sample steps through S_GAIN, S_X, S_B0, S_Y, an S_A/S_Z pair per order and S_DONE.
// All products go through the single shared 32x32 multiplier, so a new sample is taken only in S_IDLE.
// The result register frees the input side while a finished sample waits to be taken.
// Reset (synchronous, active low) clears the delay lines, the control state and the
// coefficients to b0 = 1.0, gain = 1.0 and all others zero.
// ------------------------------------------------------------------------
// iir_filter_transposed_df2
// Multichannel transposed direct form II IIR filter built around one shared
// multiplier and rounding unit driven by a small sequencer.
// ------------------------------------------------------------------------
`default_nettype none

module iir_filter_transposed_df2 #(
    parameter int ORDER    = iirtdf2_pkg::ORDER_DEF,
    parameter int CHANNELS = iirtdf2_pkg::CHANNELS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire signed [iirtdf2_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire                                    i_channel,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [iirtdf2_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                   o_channel_out,
    input  wire                                    i_cfg_we,
    input  wire        [iirtdf2_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire        [iirtdf2_pkg::COEF_W-1:0]   i_cfg_data
);

    localparam int DEPTH = CHANNELS * ORDER;
    localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JW    = $clog2(ORDER + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_GAIN = 8'b0000_0010,
        S_X    = 8'b0000_0100,
        S_B0   = 8'b0000_1000,
        S_Y    = 8'b0001_0000,
        S_A    = 8'b0010_0000,
        S_Z    = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [iirtdf2_pkg::COEF_W-1:0]   r_cfg [iirtdf2_pkg::CFG_N];
    logic signed [iirtdf2_pkg::DELAY_W-1:0]  r_delay [DEPTH];
    logic signed [iirtdf2_pkg::SAMPLE_W-1:0] r_s;
    logic                                    r_ch;
    logic signed [iirtdf2_pkg::X_W-1:0]      r_x;
    logic signed [iirtdf2_pkg::SAMPLE_W-1:0] r_y;
    logic signed [iirtdf2_pkg::PROD_W-1:0]   r_prod;
    logic signed [iirtdf2_pkg::ACC_W-1:0]    r_acc;
    logic        [JW-1:0]                    r_j;
    logic                                    r_ov;
    logic signed [iirtdf2_pkg::SAMPLE_W-1:0] r_out;
    logic                                    r_och;

    iirtdf2_pkg::t_cfg_idx                   c_idx;
    logic signed [iirtdf2_pkg::COEF_W-1:0]   c_op_a;
    logic signed [iirtdf2_pkg::COEF_W-1:0]   c_op_b;
    logic signed [iirtdf2_pkg::PROD_W-1:0]   c_mul;
    logic signed [iirtdf2_pkg::ACC_W-1:0]    c_rnd;
    logic        [DW-1:0]                    c_rd_idx;
    logic        [DW-1:0]                    c_wr_idx;
    logic signed [iirtdf2_pkg::ACC_W-1:0]    c_z;
    logic                                    c_last;
    logic                                    c_in_ok;
    logic                                    c_load;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_sample_out  = r_out;
    assign o_channel_out = r_och;

    assign c_in_ok = (int'(i_channel) < CHANNELS);
    assign c_last  = (int'(r_j) == ORDER);
    assign c_load  = (r_state == S_DONE) && (!r_ov || i_ready);

    assign c_rnd = iirtdf2_pkg::ACC_W'(iirtdf2_pkg::round_q28(r_prod));

    always_comb begin
        c_rd_idx = DW'(int'(r_ch) * ORDER
                       + (((r_state == S_A) && !c_last) ? int'(r_j) : 0));
        c_wr_idx = DW'(int'(r_ch) * ORDER + int'(r_j) - 1);
        if ((r_state == S_A) && c_last) begin
            c_z = '0;
        end else begin
            c_z = iirtdf2_pkg::ACC_W'(r_delay[c_rd_idx]);
        end
    end

    always_comb begin
        unique case (r_state)
            S_GAIN:  c_idx = iirtdf2_pkg::CFG_GAIN;
            S_B0:    c_idx = iirtdf2_pkg::CFG_B0;
            S_Y:     c_idx = iirtdf2_pkg::CFG_B1;
            S_A:     c_idx = iirtdf2_pkg::CFG_B3 + iirtdf2_pkg::CFG_IDX_W'(r_j);
            S_Z:     c_idx = iirtdf2_pkg::CFG_B1 + iirtdf2_pkg::CFG_IDX_W'(r_j);
            default: c_idx = iirtdf2_pkg::CFG_B0;
        endcase
        unique case (r_state)
            S_GAIN:  c_op_b = iirtdf2_pkg::COEF_W'(r_s);
            S_A:     c_op_b = iirtdf2_pkg::COEF_W'(r_y);
            default: c_op_b = iirtdf2_pkg::COEF_W'(r_x);
        endcase
        c_op_a = r_cfg[c_idx];
    end

    assign c_mul = c_op_a * c_op_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && c_in_ok) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: n_state = S_X;
            S_X:    n_state = S_B0;
            S_B0:   n_state = S_Y;
            S_Y:    n_state = S_A;
            S_A:    n_state = S_Z;
            S_Z: begin
                n_state = c_last ? S_DONE : S_A;
            end
            S_DONE: begin
                if (c_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_j     <= '0;
            for (int i = 0; i < iirtdf2_pkg::CFG_N; i++) begin
                if ((i == int'(iirtdf2_pkg::CFG_B0)) || (i == int'(iirtdf2_pkg::CFG_GAIN))) begin
                    r_cfg[i] <= iirtdf2_pkg::COEF_ONE;
                end else begin
                    r_cfg[i] <= iirtdf2_pkg::COEF_ZERO;
                end
            end
            for (int i = 0; i < DEPTH; i++) begin
                r_delay[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            r_ov <= c_load || (r_ov && !i_ready);
            if (r_state == S_Y) begin
                r_j <= JW'(1);
            end else if ((r_state == S_Z) && !c_last) begin
                r_j <= r_j + JW'(1);
            end
            if (r_state == S_Z) begin
                r_delay[c_wr_idx] <= iirtdf2_pkg::sat48(r_acc - c_rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_s  <= i_sample_in;
            r_ch <= i_channel;
        end
        if ((r_state == S_GAIN) || (r_state == S_B0) || (r_state == S_Y)
                || (r_state == S_A) || ((r_state == S_Z) && !c_last)) begin
            r_prod <= c_mul;
        end
        if (r_state == S_X) begin
            r_x <= c_rnd[iirtdf2_pkg::X_W-1:0];
        end
        if (r_state == S_Y) begin
            r_y <= iirtdf2_pkg::sat24(c_rnd + c_z);
        end
        if (r_state == S_A) begin
            r_acc <= c_rnd + c_z;
        end
        if (c_load) begin
            r_out <= r_y;
            r_och <= r_ch;
        end
    end

endmodule

`default_nettype wire

>>> rtl/iirtdf2_checker.sv
// ------------------------------------------------------------------------
// iirtdf2_checker
// Port-level checks for the IIR filter, attached to the top level by bind.
// ------------------------------------------------------------------------
`default_nettype none

`include "iir_filter_transposed_df2_defines.svh"

module iirtdf2_checker #(
    parameter int CHANNELS = iirtdf2_pkg::CHANNELS_DEF
) (
    input wire                                    i_clk,
    input wire                                    i_rst_n,
    input wire                                    i_valid,
    input wire                                    o_ready,
    input wire                                    i_channel,
    input wire                                    o_valid,
    input wire                                    i_ready,
    input wire signed [iirtdf2_pkg::SAMPLE_W-1:0] o_sample_out,
    input wire                                    o_channel_out
);

    logic c_in_ok;

    assign c_in_ok = (int'(i_channel) < CHANNELS);

    `IIRTDF2_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sample_out) && $stable(o_channel_out))

    `IIRTDF2_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready && c_in_ok, !o_ready)

    `IIRTDF2_ASSERT_IMPL(a_result_frees_input, i_clk, i_rst_n, $rose(o_valid), o_ready)

    `IIRTDF2_ASSERT_NEXT(a_drop_stays_ready, i_clk, i_rst_n, i_valid && o_ready && !c_in_ok, o_ready)

endmodule

bind iir_filter_transposed_df2 iirtdf2_checker #(
    .CHANNELS(CHANNELS)
) u_iirtdf2_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_channel     (i_channel),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_sample_out  (o_sample_out),
    .o_channel_out (o_channel_out)
);

`default_nettype wire

>>> test/testbench.sv
// ------------------------------------------------------------------------
// Testbench for the transposed direct form II IIR filter
// Sends signed samples on both channels under several coefficient sets,
// including the extreme ones. The sender and the receiver pause at random.
// A scoreboard models the fixed-point filter for each accepted input
// transaction and compares every output transaction against its queue of
// expected samples.
// ------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = iirtdf2_pkg::SAMPLE_W;
    localparam int COEF_W       = iirtdf2_pkg::COEF_W;
    localparam int DELAY_W      = iirtdf2_pkg::DELAY_W;
    localparam int ORDER_DEF    = iirtdf2_pkg::ORDER_DEF;
    localparam int CHANNELS_DEF = iirtdf2_pkg::CHANNELS_DEF;
    localparam int CFG_N        = iirtdf2_pkg::CFG_N;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 106;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;
    localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } t_filtered;

    class filter_scoreboard;
        logic signed [COEF_W-1:0]  coef_b [0:ORDER_DEF];
        logic signed [COEF_W-1:0]  coef_a [0:ORDER_DEF];
        logic signed [COEF_W-1:0]  gain;
        logic signed [DELAY_W-1:0] delay_line [0:CHANNELS_DEF-1][0:ORDER_DEF-1];
        t_filtered                 expected_q [$];
        int                        errors;

        function new();
            for (int j = 0; j <= ORDER_DEF; j++) begin
                coef_b[j] = iirtdf2_pkg::COEF_ZERO;
                coef_a[j] = iirtdf2_pkg::COEF_ZERO;
            end
            coef_b[0] = iirtdf2_pkg::COEF_ONE;
            gain      = iirtdf2_pkg::COEF_ONE;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                for (int j = 0; j < ORDER_DEF; j++) begin
                    delay_line[c][j] = '0;
                end
            end
            errors = 0;
        endfunction

        function void load_coef(iirtdf2_pkg::t_cfg_idx idx, logic [COEF_W-1:0] value);
            case (idx)
                iirtdf2_pkg::CFG_B0:   coef_b[0] = value;
                iirtdf2_pkg::CFG_B1:   coef_b[1] = value;
                iirtdf2_pkg::CFG_B2:   coef_b[2] = value;
                iirtdf2_pkg::CFG_B3:   coef_b[3] = value;
                iirtdf2_pkg::CFG_A1:   coef_a[1] = value;
                iirtdf2_pkg::CFG_A2:   coef_a[2] = value;
                iirtdf2_pkg::CFG_A3:   coef_a[3] = value;
                iirtdf2_pkg::CFG_GAIN: gain      = value;
                default: ;
            endcase
        endfunction

        function longint round_q23(longint p);
            return (p + longint'(iirtdf2_pkg::HALF_Q28)) >>> 28;
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                return hi;
            end
            if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] s, logic ch);
            longint    x;
            longint    y;
            longint    acc;
            longint    nxt;
            t_filtered r;
            x = round_q23(longint'(s) * longint'(gain));
            y = clamp(round_q23(longint'(coef_b[0]) * x) + longint'(delay_line[ch][0]),
                      SAMPLE_W);
            for (int j = 1; j <= ORDER_DEF; j++) begin
                nxt = 0;
                if (j < ORDER_DEF) begin
                    nxt = longint'(delay_line[ch][j]);
                end
                acc = round_q23(longint'(coef_b[j]) * x) + nxt
                      - round_q23(longint'(coef_a[j]) * y);
                acc = clamp(acc, DELAY_W);
                delay_line[ch][j-1] = acc[DELAY_W-1:0];
            end
            r.sample  = y[SAMPLE_W-1:0];
            r.channel = ch;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] s, logic ch);
            t_filtered e;
            if (expected_q.size() == 0) begin
                $error("unexpected output transaction: sample_out %0d, channel_out %0d", s, ch);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (s !== e.sample) begin
                $error("sample_out: expected %0d, got %0d", e.sample, s);
                errors++;
            end
            if (ch !== e.channel) begin
                $error("channel_out: expected %0d, got %0d", e.channel, ch);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic                        o_ready;
    logic signed [SAMPLE_W-1:0]  i_sample_in  = '0;
    logic                        i_channel    = 1'b0;
    logic                        o_valid;
    logic                        i_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_sample_out;
    logic                        o_channel_out;
    logic                        i_cfg_we     = 1'b0;
    iirtdf2_pkg::t_cfg_idx       i_cfg_index  = iirtdf2_pkg::CFG_B0;
    logic [COEF_W-1:0]           i_cfg_data   = '0;

    filter_scoreboard  sb;
    logic [COEF_W-1:0] setup [CFG_N];
    int                burst_left = 0;
    int                cycles     = 0;

    iir_filter_transposed_df2 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_in   (i_sample_in),
        .i_channel     (i_channel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample_out  (o_sample_out),
        .o_channel_out (o_channel_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_input(i_sample_in, i_channel);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_sample_out, o_channel_out);
        end
    end

    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int stall;
        forever begin
            stall = pause_length();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(30, 150)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic ch);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap = 0;
        end else begin
            gap = pause_length();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= s;
        i_channel   <= ch;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_setup();
        i_cfg_we <= 1'b1;
        for (int k = 0; k < CFG_N; k++) begin
            i_cfg_index <= iirtdf2_pkg::t_cfg_idx'(k);
            i_cfg_data  <= setup[k];
            @(posedge i_clk);
            sb.load_coef(iirtdf2_pkg::t_cfg_idx'(k), setup[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] random_coef(int mode);
        case (mode)
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1:       return SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(24'sd1, 1'b0);
        send_sample(24'sh55_5555, 1'b1);
        send_sample(24'shAA_AAAA, 1'b0);
        drain();

        setup[iirtdf2_pkg::CFG_B0]   = COEF_MAX;
        setup[iirtdf2_pkg::CFG_B1]   = COEF_MIN;
        setup[iirtdf2_pkg::CFG_B2]   = COEF_MAX;
        setup[iirtdf2_pkg::CFG_B3]   = COEF_MIN;
        setup[iirtdf2_pkg::CFG_A1]   = COEF_MAX;
        setup[iirtdf2_pkg::CFG_A2]   = COEF_MIN;
        setup[iirtdf2_pkg::CFG_A3]   = COEF_MAX;
        setup[iirtdf2_pkg::CFG_GAIN] = COEF_MAX;
        write_setup();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b1);
        send_sample(SAMPLE_MAX, 1'b1);
        drain();

        for (int k = 0; k < CFG_N; k++) begin
            setup[k] = COEF_MIN;
        end
        write_setup();
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('1, 1'b1);
        send_sample('0, 1'b0);
        drain();

        setup[iirtdf2_pkg::CFG_B0]   = 32'h0800_0000;
        setup[iirtdf2_pkg::CFG_B1]   = 32'h0400_0000;
        setup[iirtdf2_pkg::CFG_B2]   = 32'hFE00_0000;
        setup[iirtdf2_pkg::CFG_B3]   = 32'h0100_0000;
        setup[iirtdf2_pkg::CFG_A1]   = 32'hE800_0000;
        setup[iirtdf2_pkg::CFG_A2]   = 32'h0B33_3333;
        setup[iirtdf2_pkg::CFG_A3]   = 32'hFE66_6666;
        setup[iirtdf2_pkg::CFG_GAIN] = 32'h2000_0000;
        write_setup();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int k = 0; k < CFG_N; k++) begin
                setup[k] = random_coef(p % 3);
            end
            write_setup();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(random_sample(), 1'($urandom));
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> iir_filter_transposed_df2.f
+incdir+rtl
rtl/iirtdf2_pkg.sv
rtl/iir_filter_transposed_df2.sv
rtl/iirtdf2_checker.sv
test/testbench.sv
